// File: hdl/prrjq_pkg.sv
// Package with the shared types and constants of the priority job queue.
`timescale 1ns / 1ps

package prrjq_pkg;

    localparam int DEPTH   = 128;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ID_W    = 10;
    localparam int TIME_W  = 8;
    localparam int PRIO_W  = 4;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 8;

    localparam logic [TIME_W-1:0] SLICE_RESET = 8'd25;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic ACT_ADD      = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_REINSERT
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] rem;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        t_cell_op          op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] rem;
        logic [PRIO_W-1:0] prio;
    } t_cmd;

endpackage

// File: hdl/prrjq_cell.sv
// One slot of the sorted job chain: holds a job and trades it with its neighbors.
`timescale 1ns / 1ps

module prrjq_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  prrjq_pkg::t_cmd   i_cmd,
    input  prrjq_pkg::t_entry i_left,
    input  logic             i_left_move,
    input  prrjq_pkg::t_entry i_right,
    output prrjq_pkg::t_entry o_entry,
    output logic             o_move
);

    prrjq_pkg::t_entry r_entry;
    prrjq_pkg::t_entry n_entry;

    // A cell gives way to a new job when it is empty or holds a strictly worse priority.
    assign o_move  = !r_entry.valid || (r_entry.prio > i_cmd.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            prrjq_pkg::OP_POP: begin
                n_entry = i_right;
            end
            prrjq_pkg::OP_INSERT: begin
                if (o_move) begin
                    if (i_left_move) begin
                        n_entry = i_left;
                    end else begin
                        n_entry.valid = 1'b1;
                        n_entry.id    = i_cmd.id;
                        n_entry.rem   = i_cmd.rem;
                        n_entry.prio  = i_cmd.prio;
                    end
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.id   <= n_entry.id;
        r_entry.rem  <= n_entry.rem;
        r_entry.prio <= n_entry.prio;
    end

endmodule

// File: hdl/priority_round_robin_job_queue_unit.sv
// Top level of the priority job queue with round-robin slices among equal priorities.
//
// Input channel (i_in_valid / o_in_stall) carries one item: an add (job id, burst,
// priority) or a dispatch. Output channel (o_out_valid / i_out_stall) returns one
// result item per input item from a result register.
// The jobs sit sorted in a chain of DEPTH cells; cell 0 is always the next job.
// An add moves every worse-priority job one cell right and inserts the new job.
// A dispatch reads cell 0 and cell 1, shifts the chain left, and if the job is not
// finished reinserts it in the ST_REINSERT state that follows. Items are taken at one
// per cycle for adds and finished dispatches while the receiver does not stall; a requeued
// dispatch stalls input in ST_REINSERT, as the single insert bus is shared along the chain.
// The result is registered and appears the cycle after the item is accepted.
// While the result register is full and the receiver stalls, no new item is taken.
// Reset clears the chain's valid bits, the job count and the result valid flag, and
// sets the slice length to 25. The slice register is written by i_cfg_wr_en / i_cfg_wr_data.
`timescale 1ns / 1ps

module priority_round_robin_job_queue_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [prrjq_pkg::TIME_W-1:0]  i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [prrjq_pkg::ID_W-1:0]    i_job_id,
    input  logic [prrjq_pkg::TIME_W-1:0]  i_job_len,
    input  logic [prrjq_pkg::PRIO_W-1:0]  i_priority_req,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [prrjq_pkg::STAT_W-1:0]  o_status,
    output logic [prrjq_pkg::ID_W-1:0]    o_out_job_id,
    output logic [prrjq_pkg::TIME_W-1:0]  o_run_time,
    output logic [prrjq_pkg::TIME_W-1:0]  o_remaining_after,
    output logic [prrjq_pkg::PRIO_W-1:0]  o_out_priority,
    output logic                          o_job_done,
    output logic [prrjq_pkg::OCC_W-1:0]   o_occupancy
);

    localparam int DEPTH  = prrjq_pkg::DEPTH;
    localparam int CNT_W  = prrjq_pkg::CNT_W;
    localparam int TIME_W = prrjq_pkg::TIME_W;
    localparam int OCC_W  = prrjq_pkg::OCC_W;

    prrjq_pkg::t_state r_state;
    prrjq_pkg::t_state n_state;

    logic [TIME_W-1:0] r_slice_len;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    prrjq_pkg::t_entry r_held;
    prrjq_pkg::t_cmd   w_cmd;

    prrjq_pkg::t_entry w_entry [DEPTH];
    logic              w_move  [DEPTH];

    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    logic              w_shared;
    logic [TIME_W-1:0] w_grant;
    logic [TIME_W-1:0] w_rem_after;
    logic              w_out_free;

    // Occupancy reports the job count modulo 256.
    function automatic logic [OCC_W-1:0] OCC_W_CAST(input logic [CNT_W-1:0] v);
        return OCC_W'(v);
    endfunction

    // ---------------------------------------------------------------- chain
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            prrjq_pkg::t_entry w_left;
            prrjq_pkg::t_entry w_right;
            logic              w_left_move;
            if (gi == 0) begin : g_first
                assign w_left      = '0;
                assign w_left_move = 1'b0;
            end else begin : g_mid
                assign w_left      = w_entry[gi-1];
                assign w_left_move = w_move[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_entry[gi+1];
            end
            prrjq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_left      (w_left),
                .i_left_move (w_left_move),
                .i_right     (w_right),
                .o_entry     (w_entry[gi]),
                .o_move      (w_move[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------ datapath
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != prrjq_pkg::ST_IDLE) || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // The head shares its priority with the next job only if that job is queued.
    assign w_shared    = w_entry[1].valid && (w_entry[1].prio == w_entry[0].prio);
    assign w_grant     = (w_shared && (w_entry[0].rem > r_slice_len)) ? r_slice_len
                                                                      : w_entry[0].rem;
    assign w_rem_after = w_entry[0].rem - w_grant;

    // ---------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            prrjq_pkg::ST_IDLE: begin
                if (w_accept && (i_action == prrjq_pkg::ACT_DISPATCH) && !w_empty
                    && (w_rem_after != '0)) begin
                    n_state = prrjq_pkg::ST_REINSERT;
                end
            end
            prrjq_pkg::ST_REINSERT: begin
                n_state = prrjq_pkg::ST_IDLE;
            end
            default: begin
                n_state = prrjq_pkg::ST_IDLE;
            end
        endcase
    end

    // ----------------------------------------------------- chain commands
    always_comb begin
        w_cmd.op   = prrjq_pkg::OP_HOLD;
        w_cmd.id   = i_job_id;
        w_cmd.rem  = i_job_len;
        w_cmd.prio = i_priority_req;
        n_count    = r_count;
        case (r_state)
            prrjq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_action == prrjq_pkg::ACT_ADD) begin
                        if (!w_full) begin
                            w_cmd.op = prrjq_pkg::OP_INSERT;
                            n_count  = r_count + CNT_W'(1);
                        end
                    end else if (!w_empty) begin
                        w_cmd.op = prrjq_pkg::OP_POP;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
            end
            prrjq_pkg::ST_REINSERT: begin
                w_cmd.op   = prrjq_pkg::OP_INSERT;
                w_cmd.id   = r_held.id;
                w_cmd.rem  = r_held.rem;
                w_cmd.prio = r_held.prio;
                n_count    = r_count + CNT_W'(1);
            end
            default: begin
                w_cmd.op = prrjq_pkg::OP_HOLD;
            end
        endcase
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= prrjq_pkg::ST_IDLE;
            r_count      <= '0;
            r_slice_len  <= prrjq_pkg::SLICE_RESET;
            o_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_wr_en) begin
                r_slice_len <= i_cfg_wr_data;
            end
            if (w_accept) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_held.valid <= 1'b1;
            r_held.id    <= w_entry[0].id;
            r_held.rem   <= w_rem_after;
            r_held.prio  <= w_entry[0].prio;

            o_status          <= prrjq_pkg::STATUS_OK;
            o_out_job_id      <= '0;
            o_run_time        <= '0;
            o_remaining_after <= '0;
            o_out_priority    <= '0;
            o_job_done        <= 1'b0;
            o_occupancy       <= OCC_W_CAST(r_count);
            if (i_action == prrjq_pkg::ACT_ADD) begin
                if (w_full) begin
                    o_status <= prrjq_pkg::STATUS_FULL;
                end else begin
                    o_occupancy <= OCC_W_CAST(r_count + CNT_W'(1));
                end
            end else if (w_empty) begin
                o_status <= prrjq_pkg::STATUS_EMPTY;
            end else begin
                o_out_job_id      <= w_entry[0].id;
                o_run_time        <= w_grant;
                o_remaining_after <= w_rem_after;
                o_out_priority    <= w_entry[0].prio;
                if (w_rem_after == '0) begin
                    o_job_done  <= 1'b1;
                    o_occupancy <= OCC_W_CAST(r_count - CNT_W'(1));
                end
            end
        end
    end

    // ----------------------------------------------------------- assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("job count exceeds the table depth");

    a_head_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_entry[0].valid == (r_count != '0))
        else $error("head cell valid disagrees with the job count");

    a_reinsert_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prrjq_pkg::ST_REINSERT) |-> o_in_stall)
        else $error("item accepted while a job is being requeued");

    a_requeue_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_action == prrjq_pkg::ACT_DISPATCH) && !w_empty
         && (w_rem_after != '0)) |=> (r_state == prrjq_pkg::ST_REINSERT))
        else $error("unfinished dispatched job was not requeued");

endmodule
